@@ design/mjt_pkg.sv @@
// Shared constants and saturating helpers for the min-jerk trajectory step.
package mjt_pkg;

  localparam int MUL_LAT = 2;
  localparam int DIV_LAT = 66;
  localparam int PIPE_LAT = 2 * DIV_LAT + MUL_LAT + 3;
  localparam int N_TERMS = 15;

  localparam logic [31:0] STEP_TIME_RST = 32'd655;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ONE_Q32 = 64'sh1_0000_0000;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

@@ design/mjt_delay.sv @@
// Fixed-depth register delay line for pipeline alignment.
module mjt_delay #(
  parameter int W     = 64,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [0:DEPTH-1];

  always_ff @(posedge clk) begin
    sr[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      sr[i] <= sr[i-1];
    end
  end

  assign q = sr[DEPTH-1];

endmodule

@@ design/mjt_mul.sv @@
// Two-stage signed 64x64 multiply, rounded right shift, saturation.
module mjt_mul #(
  parameter int SHIFT = 32
) (
  input  logic               clk,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);

  localparam logic [63:0] S64_MAX_U = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [63:0]  ua, ub;
  logic [63:0]  ll, lh, hl, hh;
  logic         neg;
  logic [127:0] full;
  logic [63:0]  m;

  assign ua = a[63] ? (64'd0 - a) : a;
  assign ub = b[63] ? (64'd0 - b) : b;

  always_ff @(posedge clk) begin
    ll  <= ua[31:0] * ub[31:0];
    lh  <= ua[31:0] * ub[63:32];
    hl  <= ua[63:32] * ub[31:0];
    hh  <= ua[63:32] * ub[63:32];
    neg <= a[63] ^ b[63];
  end

  always_comb begin
    full = {hh, 64'd0} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0} + {64'd0, ll}
         + (128'd1 << (SHIFT - 1));
    if (full[127:64+SHIFT] != '0) begin
      m = S64_MAX_U;
    end else begin
      m = full[64+SHIFT-1:SHIFT];
      if (m[63]) begin
        m = S64_MAX_U;
      end
    end
  end

  always_ff @(posedge clk) begin
    p <= neg ? (64'sd0 - $signed(m)) : $signed(m);
  end

endmodule

@@ design/mjt_div.sv @@
// Pipelined restoring divider: round(a * 2^SHIFT / d), one quotient bit per stage.
module mjt_div #(
  parameter int SHIFT = 16
) (
  input  logic               clk,
  input  logic signed [63:0] a,
  input  logic        [31:0] d,
  output logic signed [63:0] q
);

  localparam int NST = 64;
  localparam logic [63:0] S64_MAX_U = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [63:0] w    [0:NST];
  logic [31:0] rem  [0:NST];
  logic [31:0] dd   [0:NST];
  logic        neg  [0:NST];
  logic        ovf  [0:NST];

  logic [63:0] ua, nhi;
  logic [31:0] rf, df;
  logic        rnd;
  logic [64:0] sum;
  logic [63:0] m;

  assign ua  = a[63] ? (64'd0 - a) : a;
  assign nhi = ua >> (64 - SHIFT);

  always_ff @(posedge clk) begin
    w[0]   <= ua << SHIFT;
    rem[0] <= nhi[31:0];
    dd[0]  <= d;
    neg[0] <= a[63];
    ovf[0] <= nhi >= {32'd0, d};
  end

  for (genvar k = 1; k <= NST; k++) begin : g_st
    logic [32:0] tmp;
    logic        ge;
    assign tmp = {rem[k-1], w[k-1][63]};
    assign ge  = tmp >= {1'b0, dd[k-1]};
    always_ff @(posedge clk) begin
      rem[k] <= ge ? 32'(tmp - {1'b0, dd[k-1]}) : tmp[31:0];
      w[k]   <= {w[k-1][62:0], ge};
      dd[k]  <= dd[k-1];
      neg[k] <= neg[k-1];
      ovf[k] <= ovf[k-1];
    end
  end

  always_comb begin
    rf  = rem[NST];
    df  = dd[NST];
    rnd = rf >= (df - rf);
    sum = {1'b0, w[NST]} + {64'd0, rnd};
    if (ovf[NST] || sum[64] || sum[63]) begin
      m = S64_MAX_U;
    end else begin
      m = sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    q <= neg[NST] ? (64'sd0 - $signed(m)) : $signed(m);
  end

endmodule

@@ design/min_jerk_trajectory_step.sv @@
// Min-jerk quintic trajectory step: one axis update per clock, fixed latency.
// Accepts one beat per clock whenever busy is low (busy is high only during reset).
// Each beat yields exactly one result, strobed by done for one cycle.
// Behind the input register lie two chained 66-stage dividers (normalized time and D/T,
// then D/T/T), one quotient bit per stage, followed by a two-stage multiplier and
// three saturating-sum stages.
// Results cannot be held off. step_time may be written only when no beat is in flight.
module min_jerk_trajectory_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic        [31:0] cfg_wdata,
  input  logic signed [31:0] cur_pos,
  input  logic signed [31:0] cur_vel,
  input  logic signed [31:0] cur_acc,
  input  logic signed [31:0] goal_pos,
  input  logic signed [31:0] goal_vel,
  input  logic signed [31:0] goal_acc,
  input  logic        [31:0] time_left,
  output logic               done,
  output logic signed [31:0] next_pos,
  output logic signed [31:0] next_vel,
  output logic signed [31:0] next_acc,
  output logic               step_ok
);

  localparam int DL = mjt_pkg::DIV_LAT;
  localparam int ML = mjt_pkg::MUL_LAT;
  localparam int NT = mjt_pkg::N_TERMS;
  localparam int BL_DLY = DL - 4 * ML - 1;
  localparam int ECHO_W = 32 * 3 + 1;
  localparam int GRP_W = 33 + 32 * 4;

  logic [31:0] step_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= mjt_pkg::STEP_TIME_RST;
    end else if (cfg_we) begin
      step_time <= cfg_wdata;
    end
  end

  assign busy = rst;

  // input stage
  logic               vin;
  logic signed [31:0] x, v0, a0, v1, a1;
  logic signed [32:0] dpos;
  logic        [31:0] tl;
  logic               ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      vin <= 1'b0;
    end else begin
      vin <= start && !busy;
    end
    x    <= cur_pos;
    v0   <= cur_vel;
    a0   <= cur_acc;
    v1   <= goal_vel;
    a1   <= goal_acc;
    tl   <= time_left;
    dpos <= 33'(goal_pos) - 33'(cur_pos);
    ok   <= (step_time != 32'd0) && (step_time <= time_left);
  end

  logic signed [63:0] v064, a064, v164, a164, d64;
  assign v064 = 64'(v0);
  assign a064 = 64'(a0);
  assign v164 = 64'(v1);
  assign a164 = 64'(a1);
  assign d64  = 64'(dpos);

  // first divider rank
  logic signed [63:0] s1, dt1, q0, q1, dt2;

  mjt_div #(.SHIFT(32)) u_div_s (
    .clk(clk), .a({32'd0, step_time}), .d(tl), .q(s1));
  mjt_div #(.SHIFT(FRAC_BITS)) u_div_dt1 (.clk(clk), .a(d64), .d(tl), .q(dt1));
  mjt_div #(.SHIFT(FRAC_BITS)) u_div_q0 (.clk(clk), .a(v064), .d(tl), .q(q0));
  mjt_div #(.SHIFT(FRAC_BITS)) u_div_q1 (.clk(clk), .a(v164), .d(tl), .q(q1));

  logic [31:0] tl_dl;
  mjt_delay #(.W(32), .DEPTH(DL)) u_dly_tl (.clk(clk), .d(tl), .q(tl_dl));

  mjt_div #(.SHIFT(FRAC_BITS)) u_div_dt2 (.clk(clk), .a(dt1), .d(tl_dl), .q(dt2));

  // powers of s
  logic signed [63:0] s_d2, s_d4, s_d6, s_d8, s2, s3, s4, s5;
  logic signed [63:0] s2_d, s3_d, s4_d;

  mjt_delay #(.W(64), .DEPTH(ML)) u_dly_s2 (.clk(clk), .d(s1), .q(s_d2));
  mjt_delay #(.W(64), .DEPTH(ML)) u_dly_s4 (.clk(clk), .d(s_d2), .q(s_d4));
  mjt_delay #(.W(64), .DEPTH(ML)) u_dly_s6 (.clk(clk), .d(s_d4), .q(s_d6));
  mjt_delay #(.W(64), .DEPTH(ML)) u_dly_s8 (.clk(clk), .d(s_d6), .q(s_d8));

  mjt_mul #(.SHIFT(32)) u_mul_s2 (.clk(clk), .a(s1), .b(s1), .p(s2));
  mjt_mul #(.SHIFT(32)) u_mul_s3 (.clk(clk), .a(s2), .b(s_d2), .p(s3));
  mjt_mul #(.SHIFT(32)) u_mul_s4 (.clk(clk), .a(s3), .b(s_d4), .p(s4));
  mjt_mul #(.SHIFT(32)) u_mul_s5 (.clk(clk), .a(s4), .b(s_d6), .p(s5));

  mjt_delay #(.W(64), .DEPTH(3 * ML)) u_dly_p2 (.clk(clk), .d(s2), .q(s2_d));
  mjt_delay #(.W(64), .DEPTH(2 * ML)) u_dly_p3 (.clk(clk), .d(s3), .q(s3_d));
  mjt_delay #(.W(64), .DEPTH(ML)) u_dly_p4 (.clk(clk), .d(s4), .q(s4_d));

  // blend polynomials
  logic signed [63:0] bl_next [0:NT-1];
  logic        [63:0] bl_r    [0:NT-1];
  logic        [63:0] bl_d    [0:NT-1];

  always_comb begin
    bl_next[0]  = 64'sd10 * s3_d - 64'sd15 * s4_d + 64'sd6 * s5;
    bl_next[1]  = s_d8 - 64'sd6 * s3_d + 64'sd8 * s4_d - 64'sd3 * s5;
    bl_next[2]  = -64'sd4 * s3_d + 64'sd7 * s4_d - 64'sd3 * s5;
    bl_next[3]  = s2_d - 64'sd3 * s3_d + 64'sd3 * s4_d - s5;
    bl_next[4]  = s3_d - 64'sd2 * s4_d + s5;
    bl_next[5]  = 64'sd30 * s2_d - 64'sd60 * s3_d + 64'sd30 * s4_d;
    bl_next[6]  = mjt_pkg::ONE_Q32 - 64'sd18 * s2_d + 64'sd32 * s3_d - 64'sd15 * s4_d;
    bl_next[7]  = -64'sd12 * s2_d + 64'sd28 * s3_d - 64'sd15 * s4_d;
    bl_next[8]  = 64'sd2 * s_d8 - 64'sd9 * s2_d + 64'sd12 * s3_d - 64'sd5 * s4_d;
    bl_next[9]  = 64'sd3 * s2_d - 64'sd8 * s3_d + 64'sd5 * s4_d;
    bl_next[10] = 64'sd60 * s_d8 - 64'sd180 * s2_d + 64'sd120 * s3_d;
    bl_next[11] = -64'sd36 * s_d8 + 64'sd96 * s2_d - 64'sd60 * s3_d;
    bl_next[12] = -64'sd24 * s_d8 + 64'sd84 * s2_d - 64'sd60 * s3_d;
    bl_next[13] = mjt_pkg::ONE_Q32 - 64'sd9 * s_d8 + 64'sd18 * s2_d - 64'sd10 * s3_d;
    bl_next[14] = 64'sd3 * s_d8 - 64'sd12 * s2_d + 64'sd10 * s3_d;
  end

  for (genvar i = 0; i < NT; i++) begin : g_bl
    always_ff @(posedge clk) begin
      bl_r[i] <= bl_next[i];
    end
    mjt_delay #(.W(64), .DEPTH(BL_DLY)) u_dly_bl (.clk(clk), .d(bl_r[i]), .q(bl_d[i]));
  end

  // time-scaled state
  logic signed [63:0] v0t, v1t, a0t, a1t, a0tt, a1tt;
  logic        [31:0] tl_ml;
  logic signed [63:0] t64;
  assign t64 = {32'd0, tl};

  mjt_mul #(.SHIFT(FRAC_BITS)) u_mul_v0t (.clk(clk), .a(v064), .b(t64), .p(v0t));
  mjt_mul #(.SHIFT(FRAC_BITS)) u_mul_v1t (.clk(clk), .a(v164), .b(t64), .p(v1t));
  mjt_mul #(.SHIFT(FRAC_BITS)) u_mul_a0t (.clk(clk), .a(a064), .b(t64), .p(a0t));
  mjt_mul #(.SHIFT(FRAC_BITS)) u_mul_a1t (.clk(clk), .a(a164), .b(t64), .p(a1t));

  mjt_delay #(.W(32), .DEPTH(ML)) u_dly_tlm (.clk(clk), .d(tl), .q(tl_ml));

  mjt_mul #(.SHIFT(FRAC_BITS)) u_mul_a0tt (
    .clk(clk), .a(a0t), .b({32'd0, tl_ml}), .p(a0tt));
  mjt_mul #(.SHIFT(FRAC_BITS)) u_mul_a1tt (
    .clk(clk), .a(a1t), .b({32'd0, tl_ml}), .p(a1tt));

  // alignment to the term multipliers, the sums and the result register
  logic [GRP_W-1:0] grp_d;
  logic [255:0]     tprod_d;
  logic [127:0]     ttprod_d;
  logic [191:0]     quo_d;
  logic [31:0]      x_sum;
  logic [ECHO_W-1:0] echo_d;

  mjt_delay #(.W(GRP_W), .DEPTH(2 * DL)) u_dly_grp (
    .clk(clk), .d({dpos, v0, v1, a0, a1}), .q(grp_d));
  mjt_delay #(.W(256), .DEPTH(2 * DL - ML)) u_dly_tp (
    .clk(clk), .d({v0t, v1t, a0t, a1t}), .q(tprod_d));
  mjt_delay #(.W(128), .DEPTH(2 * DL - 2 * ML)) u_dly_ttp (
    .clk(clk), .d({a0tt, a1tt}), .q(ttprod_d));
  mjt_delay #(.W(192), .DEPTH(DL)) u_dly_quo (
    .clk(clk), .d({dt1, q0, q1}), .q(quo_d));
  mjt_delay #(.W(32), .DEPTH(2 * DL + ML)) u_dly_x (.clk(clk), .d(x), .q(x_sum));
  mjt_delay #(.W(ECHO_W), .DEPTH(2 * DL + ML + 2)) u_dly_echo (
    .clk(clk), .d({x, v0, a0, ok}), .q(echo_d));

  logic signed [63:0] ta [0:NT-1];
  logic signed [63:0] tp [0:NT-1];

  always_comb begin
    ta[0]  = 64'($signed(grp_d[160:128]));
    ta[1]  = tprod_d[255:192];
    ta[2]  = tprod_d[191:128];
    ta[3]  = ttprod_d[127:64];
    ta[4]  = ttprod_d[63:0];
    ta[5]  = quo_d[191:128];
    ta[6]  = 64'($signed(grp_d[127:96]));
    ta[7]  = 64'($signed(grp_d[95:64]));
    ta[8]  = tprod_d[127:64];
    ta[9]  = tprod_d[63:0];
    ta[10] = dt2;
    ta[11] = quo_d[127:64];
    ta[12] = quo_d[63:0];
    ta[13] = 64'($signed(grp_d[63:32]));
    ta[14] = 64'($signed(grp_d[31:0]));
  end

  for (genvar i = 0; i < NT; i++) begin : g_term
    localparam int SH = (i == 3 || i == 4 || i == 8 || i == 9) ? 33 : 32;
    mjt_mul #(.SHIFT(SH)) u_mul_t (
      .clk(clk), .a(ta[i]), .b($signed(bl_d[i])), .p(tp[i]));
  end

  // saturating sums
  logic signed [63:0] pa, va, aa, pb, vb, ab;
  logic signed [63:0] p2a, p3a, p4a, v2a, v3a, v4a, c2a, c3a, c4a;
  logic signed [63:0] p4b, v4b, c4b;
  logic signed [63:0] pos_f, vel_f, acc_f;

  always_ff @(posedge clk) begin
    pa  <= mjt_pkg::sat_add(mjt_pkg::sat_add(64'($signed(x_sum)), tp[0]), tp[1]);
    va  <= mjt_pkg::sat_add(tp[5], tp[6]);
    aa  <= mjt_pkg::sat_add(tp[10], tp[11]);
    p2a <= tp[2];
    p3a <= tp[3];
    p4a <= tp[4];
    v2a <= tp[7];
    v3a <= tp[8];
    v4a <= tp[9];
    c2a <= tp[12];
    c3a <= tp[13];
    c4a <= tp[14];
    pb  <= mjt_pkg::sat_add(mjt_pkg::sat_add(pa, p2a), p3a);
    vb  <= mjt_pkg::sat_add(mjt_pkg::sat_add(va, v2a), v3a);
    ab  <= mjt_pkg::sat_add(mjt_pkg::sat_add(aa, c2a), c3a);
    p4b <= p4a;
    v4b <= v4a;
    c4b <= c4a;
  end

  assign pos_f = mjt_pkg::sat_add(pb, p4b);
  assign vel_f = mjt_pkg::sat_add(vb, v4b);
  assign acc_f = mjt_pkg::sat_add(ab, c4b);

  // valid line and result register
  logic vld [0:mjt_pkg::PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mjt_pkg::PIPE_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= vin;
      for (int i = 1; i < mjt_pkg::PIPE_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  assign done = vld[mjt_pkg::PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (echo_d[0]) begin
      next_pos <= mjt_pkg::sat32(pos_f);
      next_vel <= mjt_pkg::sat32(vel_f);
      next_acc <= mjt_pkg::sat32(acc_f);
    end else begin
      next_pos <= echo_d[96:65];
      next_vel <= echo_d[64:33];
      next_acc <= echo_d[32:1];
    end
    step_ok <= echo_d[0];
  end

endmodule

@@ design/mjt_checker.sv @@
// Port-level checks for the min-jerk trajectory step, bound to the top level.
module mjt_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_busy_rst: assert property (@(posedge clk) busy == rst)
    else $error("busy outside reset");

  a_rst_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(mjt_pkg::PIPE_LAT + 1) done)
    else $error("accepted beat produced no result");

  a_lat_rev: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, mjt_pkg::PIPE_LAT + 1))
    else $error("result without matching beat");

endmodule

bind min_jerk_trajectory_step mjt_checker u_mjt_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done));

@@ tb/min_jerk_trajectory_step_chk.sv @@
// Checker: predicts each min-jerk step result and compares it with the block's output.
`timescale 1ns / 100ps

module min_jerk_trajectory_step_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               cfg_we,
  input  logic        [31:0] cfg_wdata,
  input  logic signed [31:0] cur_pos,
  input  logic signed [31:0] cur_vel,
  input  logic signed [31:0] cur_acc,
  input  logic signed [31:0] goal_pos,
  input  logic signed [31:0] goal_vel,
  input  logic signed [31:0] goal_acc,
  input  logic        [31:0] time_left,
  input  logic               done,
  input  logic signed [31:0] next_pos,
  input  logic signed [31:0] next_vel,
  input  logic signed [31:0] next_acc,
  input  logic               step_ok,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
    logic               ok;
  } step_res_t;

  localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  step_res_t   step_q[$];
  logic [31:0] dt_reg;

  function automatic longint apply_sign(logic [63:0] m, bit neg);
    if (m > MAG_MAX) begin
      m = MAG_MAX;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] mag(longint v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    return m;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > mjt_pkg::S64_MAX - b) begin
      return mjt_pkg::S64_MAX;
    end
    if (b < 0 && a < mjt_pkg::S64_MIN - b) begin
      return mjt_pkg::S64_MIN;
    end
    return a + b;
  endfunction

  function automatic longint mul_rnd(longint a, longint b, int n);
    logic [127:0] p;
    bit           neg;
    neg = (a < 0) != (b < 0);
    p = {64'b0, mag(a)} * {64'b0, mag(b)};
    p = p + (128'd1 << (n - 1));
    if ((p >> (64 + n)) != 0) begin
      return apply_sign(MAG_MAX, neg);
    end
    p = p >> n;
    return apply_sign(p[63:0], neg);
  endfunction

  function automatic longint div_rnd(longint a, logic [63:0] d, int n);
    logic [127:0] num, q, r;
    bit           neg;
    neg = a < 0;
    if (d == 0) begin
      return apply_sign((a != 0) ? MAG_MAX : 64'd0, neg);
    end
    num = {64'b0, mag(a)} << n;
    q = num / {64'b0, d};
    r = num % {64'b0, d};
    if (r >= {64'b0, d} - r) begin
      q = q + 1;
    end
    if (q[127:64] != 0) begin
      return apply_sign(MAG_MAX, neg);
    end
    return apply_sign(q[63:0], neg);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic step_res_t next_point(logic [31:0] dt, longint x, longint v0, longint a0,
                                           longint g, longint v1, longint a1,
                                           logic [31:0] tl);
    step_res_t r;
    longint    tt, d, s, s2, s3, s4, s5, a0t, a1t, dt1, dt2, pos, vel, acc;
    if (dt == 0 || dt > tl) begin
      r.pos = x[31:0];
      r.vel = v0[31:0];
      r.acc = a0[31:0];
      r.ok  = 1'b0;
      return r;
    end
    tt  = longint'({32'b0, tl});
    d   = g - x;
    s   = div_rnd(longint'({32'b0, dt}), {32'b0, tl}, 32);
    s2  = mul_rnd(s, s, 32);
    s3  = mul_rnd(s2, s, 32);
    s4  = mul_rnd(s3, s, 32);
    s5  = mul_rnd(s4, s, 32);
    a0t = mul_rnd(a0, tt, 16);
    a1t = mul_rnd(a1, tt, 16);
    dt1 = div_rnd(d, {32'b0, tl}, 16);
    dt2 = div_rnd(dt1, {32'b0, tl}, 16);

    pos = x;
    pos = add_sat(pos, mul_rnd(d, 10 * s3 - 15 * s4 + 6 * s5, 32));
    pos = add_sat(pos, mul_rnd(mul_rnd(v0, tt, 16), s - 6 * s3 + 8 * s4 - 3 * s5, 32));
    pos = add_sat(pos, mul_rnd(mul_rnd(v1, tt, 16), -4 * s3 + 7 * s4 - 3 * s5, 32));
    pos = add_sat(pos, mul_rnd(mul_rnd(a0t, tt, 16), s2 - 3 * s3 + 3 * s4 - s5, 33));
    pos = add_sat(pos, mul_rnd(mul_rnd(a1t, tt, 16), s3 - 2 * s4 + s5, 33));

    vel = mul_rnd(dt1, 30 * s2 - 60 * s3 + 30 * s4, 32);
    vel = add_sat(vel, mul_rnd(v0, mjt_pkg::ONE_Q32 - 18 * s2 + 32 * s3 - 15 * s4, 32));
    vel = add_sat(vel, mul_rnd(v1, -12 * s2 + 28 * s3 - 15 * s4, 32));
    vel = add_sat(vel, mul_rnd(a0t, 2 * s - 9 * s2 + 12 * s3 - 5 * s4, 33));
    vel = add_sat(vel, mul_rnd(a1t, 3 * s2 - 8 * s3 + 5 * s4, 33));

    acc = mul_rnd(dt2, 60 * s - 180 * s2 + 120 * s3, 32);
    acc = add_sat(acc, mul_rnd(div_rnd(v0, {32'b0, tl}, 16), -36 * s + 96 * s2 - 60 * s3, 32));
    acc = add_sat(acc, mul_rnd(div_rnd(v1, {32'b0, tl}, 16), -24 * s + 84 * s2 - 60 * s3, 32));
    acc = add_sat(acc, mul_rnd(a0, mjt_pkg::ONE_Q32 - 9 * s + 18 * s2 - 10 * s3, 32));
    acc = add_sat(acc, mul_rnd(a1, 3 * s - 12 * s2 + 10 * s3, 32));

    r.pos = clamp32(pos);
    r.vel = clamp32(vel);
    r.acc = clamp32(acc);
    r.ok  = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    step_res_t want;
    if (rst) begin
      dt_reg <= mjt_pkg::STEP_TIME_RST;
      fail_count <= 0;
      pending <= 0;
      step_q.delete();
    end else begin
      if (cfg_we) begin
        dt_reg <= cfg_wdata;
      end
      if (start && !busy) begin
        step_q.push_back(next_point(dt_reg, cur_pos, cur_vel, cur_acc,
                                    goal_pos, goal_vel, goal_acc, time_left));
      end
      if (done) begin
        if (step_q.size() == 0) begin
          $display("%0t: unexpected beat: pos %h vel %h acc %h ok %b",
                   $time, next_pos, next_vel, next_acc, step_ok);
          fail_count <= fail_count + 1;
        end else begin
          want = step_q.pop_front();
          if (want.pos !== next_pos || want.vel !== next_vel || want.acc !== next_acc
              || want.ok !== step_ok) begin
            $display("%0t: expected pos %h vel %h acc %h ok %b", $time,
                     want.pos, want.vel, want.acc, want.ok);
            $display("%0t:   actual pos %h vel %h acc %h ok %b", $time,
                     next_pos, next_vel, next_acc, step_ok);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= step_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top: drives step updates and step-time writes, reports the verdict.
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               cfg_we = 1'b0;
  logic        [31:0] cfg_wdata = '0;
  logic signed [31:0] cur_pos = '0, cur_vel = '0, cur_acc = '0;
  logic signed [31:0] goal_pos = '0, goal_vel = '0, goal_acc = '0;
  logic        [31:0] time_left = '0;
  logic               done;
  logic signed [31:0] next_pos, next_vel, next_acc;
  logic               step_ok;
  int                 fail_count, pending;
  int                 cycles = 0;
  logic        [31:0] dt_now;
  bit                 no_gaps;

  always #6 clk = ~clk;

  min_jerk_trajectory_step uut (.*);
  min_jerk_trajectory_step_chk chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_time(logic [31:0] dt);
    case ($urandom_range(0, 9))
      0: return dt;
      1: return (dt == 0) ? 32'd0 : $urandom_range(0, dt - 1);
      2: return $urandom;
      3: return 32'hFFFF_FFFF;
      default: return (dt > 32'hFFFF_0000) ? 32'hFFFF_FFFF : dt + $urandom_range(0, 32'hFFFF);
    endcase
  endfunction

  task automatic send(logic [31:0] p, logic [31:0] v, logic [31:0] a, logic [31:0] gp,
                      logic [31:0] gv, logic [31:0] ga, logic [31:0] tl);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cur_pos <= p;
    cur_vel <= v;
    cur_acc <= a;
    goal_pos <= gp;
    goal_vel <= gv;
    goal_acc <= ga;
    time_left <= tl;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_step(logic [31:0] dt);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= dt;
    @(posedge clk);
    cfg_we <= 1'b0;
    dt_now = dt;
  endtask

  task automatic random_beats(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      send(pick32(), pick32(), pick32(), pick32(), pick32(), pick32(), pick_time(dt_now));
    end
  endtask

  initial begin
    logic [31:0] dt_list[7];
    dt_list = '{32'd0, 32'd1, 32'h1_0000, 32'hFFFF_FFFF, 32'd6554, 32'd655, 32'd0};
    dt_list[6] = $urandom_range(1, 32'h4_0000);
    dt_now = mjt_pkg::STEP_TIME_RST;
    no_gaps = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beats at the reset step time
    send(32'h1_0000, 0, 0, 32'h5_0000, 0, 0, 32'd0);
    send(32'h1_0000, 32'h100, 32'h10, 32'h5_0000, 0, 0, 32'd654);
    send(32'h1_0000, 32'h100, 32'h10, 32'h5_0000, 32'h2000, 32'h30, 32'd655);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000, 32'hFFFF_FFFF);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'd656);
    send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h7FFF_FFFF, 32'd655);
    send(0, 0, 0, 0, 0, 0, 32'h1_0000);
    send(32'h3_0000, 32'h1_0000, 32'hFFFF_0000, 32'h3_0000, 32'h1_0000, 32'hFFFF_0000,
         32'h2_0000);
    send(32'hFFFF_0000, 0, 0, 32'h1_0000, 0, 0, 32'h7FFF_FFFF);
    send(32'h1234_5678, 32'hEDCB_A988, 32'h0F0F_0F0F, 32'hF0F0_F0F1, 32'h5555_5555,
         32'hAAAA_AAAA, 32'h8000_0000);
    random_beats(260);

    foreach (dt_list[k]) begin
      set_step(dt_list[k]);
      if (dt_list[k] == 32'hFFFF_FFFF) begin
        send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'hFFFF_FFFF);
      end
      random_beats(230);
    end

    drain();
    repeat (mjt_pkg::PIPE_LAT + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/mjt_pkg.sv
design/mjt_delay.sv
design/mjt_mul.sv
design/mjt_div.sv
design/min_jerk_trajectory_step.sv
design/mjt_checker.sv
tb/min_jerk_trajectory_step_chk.sv
tb/tb.sv
